### src/ddip_pkg.sv
// Shared types and constants of the delimited decimal integer parser.
package ddip_pkg;

   localparam logic [7:0] DIVIDER_RESET = 8'd44;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   localparam logic [35:0] LIMIT_POS = 36'h07FFFFFFF;
   localparam logic [35:0] LIMIT_NEG = 36'h080000000;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   typedef struct packed {
      logic        nonempty;
      phase_type   phase;
      logic        negative;
      logic [31:0] acc;
      logic        ovf;
   } frag_state_type;

   typedef struct packed {
      logic signed [31:0] int_value;
      logic               value_present;
      logic               overflowed;
      logic               text_done;
   } rsp_word_type;

endpackage

### src/ddip_step.sv
// Per-character fragment parse step: next fragment state and the optional result word.
module ddip_step (
   input  ddip_pkg::frag_state_type state_cur,
   input  logic [7:0]               char_byte,
   input  logic                     end_marker,
   input  logic [7:0]               divider_char,
   output ddip_pkg::frag_state_type state_nxt,
   output logic                     has_result,
   output ddip_pkg::rsp_word_type   result
);

   logic        is_space;
   logic        is_digit;
   logic [3:0]  digit;
   logic [35:0] acc_ext;
   logic [35:0] acc_next;
   logic [35:0] limit;
   logic        digit_ovf;
   logic [31:0] signed_val;

   assign is_space = (char_byte == ddip_pkg::CHAR_SPACE) ||
                     ((char_byte >= ddip_pkg::CHAR_TAB) && (char_byte <= ddip_pkg::CHAR_CR));
   assign is_digit = (char_byte >= ddip_pkg::CHAR_ZERO) && (char_byte <= ddip_pkg::CHAR_NINE);
   assign digit    = 4'(char_byte - ddip_pkg::CHAR_ZERO);

   // Multiply by ten as two shifts and an add, kept wide to see overflow.
   assign acc_ext   = {4'b0000, state_cur.acc};
   assign acc_next  = (acc_ext << 3) + (acc_ext << 1) + {32'd0, digit};
   assign limit     = state_cur.negative ? ddip_pkg::LIMIT_NEG : ddip_pkg::LIMIT_POS;
   assign digit_ovf = acc_next > limit;

   assign signed_val = state_cur.negative ? (32'd0 - state_cur.acc) : state_cur.acc;

   always_comb begin
      state_nxt  = state_cur;
      has_result = 1'b0;
      result     = '0;
      if (end_marker) begin
         has_result       = 1'b1;
         result.text_done = 1'b1;
         if (state_cur.nonempty) begin
            result.int_value     = signed_val;
            result.value_present = 1'b1;
            result.overflowed    = state_cur.ovf;
         end
         state_nxt = '0;
      end else if (char_byte == divider_char) begin
         if (state_cur.nonempty) begin
            has_result           = 1'b1;
            result.int_value     = signed_val;
            result.value_present = 1'b1;
            result.overflowed    = state_cur.ovf;
         end
         state_nxt = '0;
      end else begin
         state_nxt.nonempty = 1'b1;
         case (state_cur.phase)
            ddip_pkg::PH_SKIP: begin
               if (is_space) begin
                  state_nxt.phase = ddip_pkg::PH_SKIP;
               end else if (char_byte == ddip_pkg::CHAR_PLUS) begin
                  state_nxt.phase = ddip_pkg::PH_DIGITS;
               end else if (char_byte == ddip_pkg::CHAR_MINUS) begin
                  state_nxt.negative = 1'b1;
                  state_nxt.phase    = ddip_pkg::PH_DIGITS;
               end else if (is_digit) begin
                  state_nxt.acc   = acc_next[31:0];
                  state_nxt.ovf   = state_cur.ovf | digit_ovf;
                  state_nxt.phase = ddip_pkg::PH_DIGITS;
               end else begin
                  state_nxt.phase = ddip_pkg::PH_STOP;
               end
            end
            ddip_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  state_nxt.acc = acc_next[31:0];
                  state_nxt.ovf = state_cur.ovf | digit_ovf;
               end else begin
                  state_nxt.phase = ddip_pkg::PH_STOP;
               end
            end
            default: begin
               state_nxt.phase = state_cur.phase;
            end
         endcase
      end
   end

endmodule

### src/ddip_out_reg.sv
// Result register that holds one result word until the consumer takes it.
module ddip_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ddip_pkg::rsp_word_type load_word,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ddip_pkg::rsp_word_type rsp_word,
   output logic                   room
);

   logic                   valid_ff;
   logic                   valid_in;
   ddip_pkg::rsp_word_type word_ff;

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

### src/delimited_decimal_int_parser_unit.sv
// Top level of the delimited decimal integer parser.
//
// The unit takes a text one character word per cycle on the req_ channel and splits it on
// the divider byte held in the csr_ register (reset value ',' = 44). Every non-empty fragment
// is converted like atoi: leading whitespace is skipped, one '+' or '-' is taken, digits are
// accumulated until the first non-digit, and a fragment without digits reads as zero. A
// fragment's result word leaves on the rsp_ channel when its closing divider arrives; empty
// fragments give nothing. An end-of-text word always gives exactly one result with
// text_done set, and value_present tells whether it carries a last value. Overflow wraps the
// value modulo 2^32 and sets the overflowed flag. The unit sustains one character word per
// cycle unless stalled: a word waits in the input register and is parsed in one pass (a
// compare plus a multiply by ten and add on the fragment accumulator). Its result word is
// registered in the output register driving rsp_ and held there until taken. Backpressure
// from rsp_ready stalls the input register only when the stalled word itself has a result to
// deliver. The divider should be written only while no text is in flight.
module delimited_decimal_int_parser_unit (
   input  logic               clock,
   input  logic               reset,
   // Character words.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_byte,
   input  logic               req_end_marker,
   // Result words.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_int_value,
   output logic               rsp_value_present,
   output logic               rsp_overflowed,
   output logic               rsp_text_done,
   // Divider register write.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_divider_char
);

   // Divider register; writes are always taken.
   logic [7:0] divider_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= ddip_pkg::DIVIDER_RESET;
      end else if (csr_valid) begin
         divider_ff <= csr_divider_char;
      end
   end

   // Input register: one character word waiting to be parsed.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_end_ff;

   // Fragment state carried from one character to the next.
   ddip_pkg::frag_state_type state_ff;
   ddip_pkg::frag_state_type state_in;
   ddip_pkg::frag_state_type step_state;

   logic                   step_has_result;
   ddip_pkg::rsp_word_type step_result;
   ddip_pkg::rsp_word_type out_word;
   logic                   out_room;
   logic                   advance;
   logic                   accept;

   ddip_step u_step (
      .state_cur    (state_ff),
      .char_byte    (in_char_ff),
      .end_marker   (in_end_ff),
      .divider_char (divider_ff),
      .state_nxt    (step_state),
      .has_result   (step_has_result),
      .result       (step_result)
   );

   // The held word is parsed and retired when its result, if any, fits in the output
   // register. Words without a result never wait on the consumer.
   assign advance   = in_valid_ff && (!step_has_result || out_room);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in = accept ? 1'b1 : (in_valid_ff && !advance);
   assign state_in    = advance ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_byte;
         in_end_ff  <= req_end_marker;
      end
   end

   ddip_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && step_has_result),
      .load_word (step_result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (out_word),
      .room      (out_room)
   );

   assign rsp_int_value     = out_word.int_value;
   assign rsp_value_present = out_word.value_present;
   assign rsp_overflowed    = out_word.overflowed;
   assign rsp_text_done     = out_word.text_done;

endmodule

### src/ddip_checker.sv
// Port-level checker of the parser unit and its bind to the top level.
module ddip_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_int_value,
   input logic               rsp_value_present,
   input logic               rsp_overflowed,
   input logic               rsp_text_done
);

   // A stalled result word keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_int_value) &&
      $stable(rsp_value_present) && $stable(rsp_overflowed) && $stable(rsp_text_done))
      else $error("result word changed while stalled");

   // Only the end of a text can give a result without a value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_present |-> rsp_text_done)
      else $error("empty result that does not close the text");

   // A result without a value reads as zero with no overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_present |-> rsp_int_value == 32'sd0 && !rsp_overflowed)
      else $error("empty result carries data");

   // Overflow is only reported on a real value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_value_present)
      else $error("overflow flag without a value");

endmodule

bind delimited_decimal_int_parser_unit ddip_checker u_ddip_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_int_value     (rsp_int_value),
   .rsp_value_present (rsp_value_present),
   .rsp_overflowed    (rsp_overflowed),
   .rsp_text_done     (rsp_text_done)
);
